[hw/rtl/erd_pkg.sv]
// ----------------------------------------------------------------------------
// erd_pkg: shared constants and types
// Widths, register indexes, status codes and unit handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package erd_pkg;

  localparam int unsigned MaxRows  = 1024;
  localparam int unsigned MaxDims  = 256;
  localparam int unsigned ElemW    = 16;
  localparam int unsigned RowW     = $clog2(MaxRows);
  localparam int unsigned DimW     = $clog2(MaxDims);
  localparam int unsigned AddrW    = RowW + DimW;
  localparam int unsigned OpW      = ElemW + 1;
  localparam int unsigned ProdW    = 2 * OpW;
  localparam int unsigned AccW     = 42;
  localparam int unsigned NormW    = 40;
  localparam int unsigned RadW     = 2 * NormW;
  localparam int unsigned RemW     = NormW + 2;
  localparam int unsigned QW       = 17;
  localparam int unsigned DistW    = 40;
  localparam int unsigned CfgW     = 11;

  localparam logic [QW-1:0] OneQ16 = QW'(65536);

  localparam logic [1:0] CfgMetric = 2'd0;
  localparam logic [1:0] CfgRows   = 2'd1;
  localparam logic [1:0] CfgDims   = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StRowRange = 2'd1;
  localparam logic [1:0] StDimRange = 2'd2;
  localparam logic [1:0] StZeroNorm = 2'd3;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic MetricCos = 1'b0;
  localparam logic MetricL2  = 1'b1;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } erd_cos_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/erd_store.sv]
// ----------------------------------------------------------------------------
// erd_store: embedding table
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module erd_store
  import erd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [ElemW-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [ElemW-1:0] rdata_a_o,
  output logic      [ElemW-1:0] rdata_b_o
);

  logic [ElemW-1:0] mem [MaxRows*MaxDims];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

[hw/rtl/erd_cos_unit.sv]
// ----------------------------------------------------------------------------
// erd_cos_unit: cosine normalisation
// Shift-add norm product, digit-by-digit square root, restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module erd_cos_unit
  import erd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [NormW-1:0]       nl_i,
  input  wire logic [NormW-1:0]       nr_i,
  input  wire logic [NormW-1:0]       mag_i,
  output erd_cos_rsp_t                rsp_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_SQRT, S_DIV} state_e;

  state_e            state_q;
  logic [5:0]        cnt_q;
  logic [NormW-1:0]  mula_q, mulb_q, root_q, mag_q;
  logic [RadW-1:0]   rad_q;
  logic [RemW-1:0]   rem_q;
  logic [NormW:0]    r_q;
  logic [QW-1:0]     q_q;
  logic              done_q;

  logic [RemW+1:0]   sq_t, sq_trial;
  logic [NormW:0]    dv_t;

  assign sq_t     = {rem_q, rad_q[RadW-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign dv_t     = {r_q[NormW-1:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            mula_q  <= nl_i;
            mulb_q  <= nr_i;
            mag_q   <= mag_i;
            rad_q   <= '0;
            cnt_q   <= 6'(NormW - 1);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          rad_q  <= {rad_q[RadW-2:0], 1'b0} + (mula_q[NormW-1] ? RadW'(mulb_q) : '0);
          mula_q <= {mula_q[NormW-2:0], 1'b0};
          if (cnt_q == '0) begin
            cnt_q   <= 6'(NormW - 1);
            root_q  <= '0;
            rem_q   <= '0;
            state_q <= S_SQRT;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_SQRT: begin
          if (sq_t >= sq_trial) begin
            rem_q  <= RemW'(sq_t - sq_trial);
            root_q <= {root_q[NormW-2:0], 1'b1};
          end else begin
            rem_q  <= RemW'(sq_t);
            root_q <= {root_q[NormW-2:0], 1'b0};
          end
          rad_q <= {rad_q[RadW-3:0], 2'b00};
          if (cnt_q == '0) begin
            cnt_q   <= 6'd16;
            r_q     <= {1'b0, mag_q};
            q_q     <= '0;
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_DIV: begin
          if (cnt_q == 6'd16) begin
            if (mag_q >= root_q) begin
              q_q     <= OneQ16;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              cnt_q <= cnt_q - 6'd1;
            end
          end else begin
            if (dv_t >= {1'b0, root_q}) begin
              r_q <= dv_t - {1'b0, root_q};
              q_q <= {q_q[QW-2:0], 1'b1};
            end else begin
              r_q <= dv_t;
              q_q <= {q_q[QW-2:0], 1'b0};
            end
            if (cnt_q == 6'd0) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              cnt_q <= cnt_q - 6'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE) else $error("start while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("done outside idle");
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> q_q <= OneQ16) else $error("quotient above one");
`endif

endmodule

`default_nettype wire

[hw/rtl/embedding_row_distance_core.sv]
// ----------------------------------------------------------------------------
// embedding_row_distance_core: embedding row distance
// Stores embedding elements and returns squared L2 or cosine row distances.
// ----------------------------------------------------------------------------
// One item at a time: a new load or query stalls while one is in flight or
// its result waits at a stalled output. A load, or a query rejected by its
// range checks, is answered straight from idle. A squared L2 or cosine query
// has one shared 17x17 multiplier walk the rows (one table read, then one
// product per term of each element); a cosine query then runs a 40-step norm
// product, a 40-step square root and a 17-step divide that stops on a clamp.
`default_nettype none

module embedding_row_distance_core
  import erd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CfgW-1:0]  cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             command_i,
  input  wire logic [RowW-1:0]  load_row_i,
  input  wire logic [DimW-1:0]  load_dim_i,
  input  wire logic signed [ElemW-1:0] load_value_i,
  input  wire logic [RowW-1:0]  lhs_row_i,
  input  wire logic [RowW-1:0]  rhs_row_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [DistW-1:0]      distance_value_o,
  output logic [1:0]            status_o
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_DRAIN, S_FIN, S_COS} state_e;

  state_e              state_q;
  logic                metric_q;
  logic [CfgW-1:0]     rows_q;
  logic [DimW:0]       dims_q;
  logic [RowW-1:0]     lhs_q, rhs_q;
  logic [DimW:0]       dim_q;
  logic [1:0]          phase_q, tag_q;
  logic                pend_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic [NormW-1:0]    nl_q, nr_q;
  logic                out_valid_q;
  logic [DistW-1:0]    dist_q;
  logic [1:0]          status_q;

  logic [ElemW-1:0]    ra, rb;
  logic signed [OpW-1:0] xa, xb, op1, op2;
  logic                in_acc, last_phase, start_cos;
  logic [NormW-1:0]    mag;
  erd_cos_rsp_t        cos_rsp;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  erd_store u_store (
    .clk_i,
    .we_i      (in_acc && command_i == CmdLoad),
    .waddr_i   ({load_row_i, load_dim_i}),
    .wdata_i   (load_value_i),
    .raddr_a_i ({lhs_q, dim_q[DimW-1:0]}),
    .raddr_b_i ({rhs_q, dim_q[DimW-1:0]}),
    .rdata_a_o (ra),
    .rdata_b_o (rb)
  );

  assign xa = {ra[ElemW-1], ra};
  assign xb = {rb[ElemW-1], rb};

  always_comb begin
    op1 = xa;
    op2 = xb;
    if (metric_q == MetricL2) begin
      op1 = xa - xb;
      op2 = xa - xb;
    end else begin
      case (phase_q)
        2'd1:    op2 = xa;
        2'd2:    op1 = xb;
        default: ;
      endcase
    end
  end

  assign last_phase = (metric_q == MetricL2) || (phase_q == 2'd2);
  assign start_cos  = (state_q == S_FIN) && (metric_q == MetricCos) &&
                      (nl_q != '0) && (nr_q != '0);
  assign mag        = acc_q[AccW-1] ? NormW'(-acc_q) : NormW'(acc_q);

  erd_cos_unit u_cos (
    .clk_i,
    .rst_ni,
    .start_i (start_cos),
    .nl_i    (nl_q),
    .nr_i    (nr_q),
    .mag_i   (mag),
    .rsp_o   (cos_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      metric_q    <= MetricCos;
      rows_q      <= '0;
      dims_q      <= (DimW+1)'(MaxDims);
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      phase_q     <= '0;
      dim_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMetric: metric_q <= cfg_data_i[0];
          CfgRows:   rows_q   <= cfg_data_i;
          CfgDims:   dims_q   <= cfg_data_i[DimW:0];
          default:   ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pend_q) begin
        case (tag_q)
          2'd1:    nl_q  <= nl_q + NormW'(prod_q);
          2'd2:    nr_q  <= nr_q + NormW'(prod_q);
          default: acc_q <= acc_q + AccW'(prod_q);
        endcase
      end
      pend_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (command_i == CmdLoad) begin
              out_valid_q <= 1'b1;
              dist_q      <= '0;
              status_q    <= StOk;
            end else if (CfgW'(lhs_row_i) >= rows_q || CfgW'(rhs_row_i) >= rows_q) begin
              out_valid_q <= 1'b1;
              dist_q      <= '0;
              status_q    <= StRowRange;
            end else if (dims_q == '0 || dims_q > (DimW+1)'(MaxDims)) begin
              out_valid_q <= 1'b1;
              dist_q      <= '0;
              status_q    <= StDimRange;
            end else begin
              lhs_q   <= lhs_row_i;
              rhs_q   <= rhs_row_i;
              dim_q   <= '0;
              phase_q <= '0;
              acc_q   <= '0;
              nl_q    <= '0;
              nr_q    <= '0;
              state_q <= S_RD;
            end
          end
        end
        S_RD: state_q <= S_MUL;
        S_MUL: begin
          prod_q <= op1 * op2;
          pend_q <= 1'b1;
          tag_q  <= phase_q;
          if (last_phase) begin
            phase_q <= '0;
            if (dim_q == dims_q - 1'b1) begin
              state_q <= S_DRAIN;
            end else begin
              dim_q   <= dim_q + 1'b1;
              state_q <= S_RD;
            end
          end else begin
            phase_q <= phase_q + 2'd1;
          end
        end
        S_DRAIN: state_q <= S_FIN;
        S_FIN: begin
          if (metric_q == MetricL2) begin
            out_valid_q <= 1'b1;
            dist_q      <= (acc_q[AccW-1:DistW] != '0) ? '1 : acc_q[DistW-1:0];
            status_q    <= StOk;
            state_q     <= S_IDLE;
          end else if (nl_q == '0 || nr_q == '0) begin
            out_valid_q <= 1'b1;
            dist_q      <= '0;
            status_q    <= StZeroNorm;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_COS;
          end
        end
        S_COS: begin
          if (cos_rsp.done) begin
            out_valid_q <= 1'b1;
            dist_q      <= acc_q[AccW-1] ? DistW'(OneQ16) + DistW'(cos_rsp.quot)
                                         : DistW'(OneQ16) - DistW'(cos_rsp.quot);
            status_q    <= StOk;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distance_value_o = dist_q;
  assign status_o         = status_q;

`ifndef ASSERT_OFF
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("beat accepted while busy");
  a_cos_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cos_rsp.done |-> state_q == S_COS) else $error("stray cosine result");
  a_zero_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != StOk |-> dist_q == '0) else $error("flagged beat not zero");
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> !out_valid_q) else $error("result slot busy at finish");
`endif

endmodule

`default_nettype wire
